FILE: hdl/otsr_pkg.sv
package otsr_pkg;

  localparam int ID_W   = 16;
  localparam int DUR_W  = 16;
  localparam int TOT_W  = 22;
  localparam int OKEY_W = 64;

  typedef enum logic [1:0] {
    REQ_ADD  = 2'd0,
    REQ_DEL  = 2'd1,
    REQ_PLAY = 2'd2,
    REQ_SORT = 2'd3
  } req_t;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_FULL     = 2'd1;
  localparam logic [1:0] STAT_EMPTY    = 2'd2;
  localparam logic [1:0] STAT_NOTFOUND = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_DEL_RD,
    ST_DEL_EV,
    ST_DEL_SH,
    ST_DEL_SW,
    ST_PLAY_RD,
    ST_PLAY_EV,
    ST_PLAY_WAIT,
    ST_SRT_RD,
    ST_SRT_EV,
    ST_SRT_EMIT,
    ST_SRT_WAIT,
    ST_WAIT
  } state_t;

  typedef struct packed {
    logic       load_req;
    logic       ptr_clr;
    logic       ptr_inc;
    logic       rd_next;
    logic       do_add;
    logic       emit_stat;
    logic [1:0] stat;
    logic       emit_play;
    logic       del_hit;
    logic       shift_wr;
    logic       del_done;
    logic       srt_start;
    logic       pass_start;
    logic       srt_eval;
    logic       srt_emit;
  } cmd_t;

  typedef struct packed {
    req_t req;
    logic full;
    logic ids_out;
    logic empty;
    logic hit;
    logic scan_end;
    logic shift_more;
    logic out_busy;
    logic out_last;
  } sts_t;

endpackage

FILE: hdl/otsr_dp.sv
module otsr_dp #(
  parameter int CAPACITY = 64,
  parameter int KEY_BITS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  otsr_pkg::cmd_t                cmd,
  output otsr_pkg::sts_t                sts,
  input  logic [1:0]                    in_req_type,
  input  logic [otsr_pkg::OKEY_W-1:0]   in_sort_key,
  input  logic [otsr_pkg::DUR_W-1:0]    in_duration_seconds,
  input  logic [otsr_pkg::ID_W-1:0]     in_target_id,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_status,
  output logic [otsr_pkg::ID_W-1:0]     out_entry_id,
  output logic [otsr_pkg::OKEY_W-1:0]   out_entry_key,
  output logic [otsr_pkg::DUR_W-1:0]    out_entry_duration,
  output logic [otsr_pkg::TOT_W-1:0]    out_total_seconds,
  output logic                          out_last
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int ENT_W = otsr_pkg::ID_W + KEY_BITS + otsr_pkg::DUR_W;

  logic [ENT_W-1:0] mem [CAPACITY];
  logic [ENT_W-1:0] rd_data_r;

  otsr_pkg::req_t               req_r;
  logic [KEY_BITS-1:0]          key_r;
  logic [otsr_pkg::DUR_W-1:0]   dur_r;
  logic [otsr_pkg::ID_W-1:0]    tgt_r;

  logic [CNT_W-1:0]             cnt_r;
  logic [16:0]                  nid_r;
  logic [otsr_pkg::TOT_W-1:0]   tot_r;
  logic [CNT_W-1:0]             ptr_r;
  logic [CNT_W-1:0]             ecnt_r;
  logic                         out_valid_r;
  logic                         bfound_r;
  logic                         pvalid_r;

  logic [KEY_BITS-1:0]          bkey_r;
  logic [CNT_W-1:0]             bidx_r;
  logic [otsr_pkg::ID_W-1:0]    bid_r;
  logic [otsr_pkg::DUR_W-1:0]   bdur_r;
  logic [KEY_BITS-1:0]          pkey_r;
  logic [CNT_W-1:0]             pidx_r;

  logic [1:0]                   ostat_r;
  logic [otsr_pkg::ID_W-1:0]    oid_r;
  logic [KEY_BITS-1:0]          okey_r;
  logic [otsr_pkg::DUR_W-1:0]   odur_r;
  logic [otsr_pkg::TOT_W-1:0]   otot_r;
  logic                         olast_r;

  logic [CNT_W-1:0]             ptr_inc;
  logic [CNT_W-1:0]             rd_sel;
  logic                         wr_en;
  logic [IDX_W-1:0]             wr_addr;
  logic [ENT_W-1:0]             wr_data;
  logic [otsr_pkg::ID_W-1:0]    rd_id;
  logic [KEY_BITS-1:0]          rd_key;
  logic [otsr_pkg::DUR_W-1:0]   rd_dur;
  logic                         elig;
  logic                         better;
  logic                         emit;

  assign ptr_inc = CNT_W'(ptr_r + 1'b1);
  assign rd_sel  = cmd.rd_next ? ptr_inc : ptr_r;
  assign wr_en   = cmd.do_add | cmd.shift_wr;
  assign wr_addr = cmd.do_add ? cnt_r[IDX_W-1:0] : ptr_r[IDX_W-1:0];
  assign wr_data = cmd.do_add ? {nid_r[15:0], key_r, dur_r} : rd_data_r;

  assign rd_id  = rd_data_r[ENT_W-1 -: otsr_pkg::ID_W];
  assign rd_key = rd_data_r[otsr_pkg::DUR_W +: KEY_BITS];
  assign rd_dur = rd_data_r[otsr_pkg::DUR_W-1:0];

  assign elig   = !pvalid_r || (rd_key > pkey_r) || ((rd_key == pkey_r) && (ptr_r > pidx_r));
  assign better = !bfound_r || (rd_key < bkey_r);
  assign emit   = cmd.emit_stat | cmd.do_add | cmd.emit_play | cmd.del_done | cmd.srt_emit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_sel[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      nid_r       <= 17'd1;
      tot_r       <= '0;
      ptr_r       <= '0;
      ecnt_r      <= '0;
      out_valid_r <= 1'b0;
      bfound_r    <= 1'b0;
      pvalid_r    <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (emit && !cmd.del_hit) begin
        out_valid_r <= 1'b1;
      end
      if (cmd.ptr_clr) begin
        ptr_r <= '0;
      end else if (cmd.ptr_inc) begin
        ptr_r <= ptr_inc;
      end
      if (cmd.do_add) begin
        cnt_r <= CNT_W'(cnt_r + 1'b1);
        nid_r <= 17'(nid_r + 1'b1);
        tot_r <= otsr_pkg::TOT_W'(tot_r + otsr_pkg::TOT_W'(dur_r));
      end
      if (cmd.del_hit) begin
        tot_r <= otsr_pkg::TOT_W'(tot_r - otsr_pkg::TOT_W'(rd_dur));
      end
      if (cmd.del_done) begin
        cnt_r <= CNT_W'(cnt_r - 1'b1);
      end
      if (cmd.srt_start) begin
        pvalid_r <= 1'b0;
        ecnt_r   <= '0;
      end
      if (cmd.pass_start) begin
        bfound_r <= 1'b0;
      end
      if (cmd.srt_eval && elig && better) begin
        bfound_r <= 1'b1;
      end
      if (cmd.srt_emit) begin
        pvalid_r <= 1'b1;
        ecnt_r   <= CNT_W'(ecnt_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r <= otsr_pkg::req_t'(in_req_type);
      key_r <= in_sort_key[KEY_BITS-1:0];
      dur_r <= in_duration_seconds;
      tgt_r <= in_target_id;
    end
    if (cmd.srt_eval && elig && better) begin
      bkey_r <= rd_key;
      bidx_r <= ptr_r;
      bid_r  <= rd_id;
      bdur_r <= rd_dur;
    end
    if (cmd.srt_emit) begin
      pkey_r <= bkey_r;
      pidx_r <= bidx_r;
    end
    if (cmd.emit_stat) begin
      ostat_r <= cmd.stat;
      oid_r   <= '0;
      okey_r  <= '0;
      odur_r  <= '0;
      otot_r  <= tot_r;
      olast_r <= 1'b1;
    end
    if (cmd.do_add) begin
      ostat_r <= otsr_pkg::STAT_OK;
      oid_r   <= nid_r[15:0];
      okey_r  <= key_r;
      odur_r  <= dur_r;
      otot_r  <= otsr_pkg::TOT_W'(tot_r + otsr_pkg::TOT_W'(dur_r));
      olast_r <= 1'b1;
    end
    if (cmd.del_hit) begin
      ostat_r <= otsr_pkg::STAT_OK;
      oid_r   <= rd_id;
      okey_r  <= rd_key;
      odur_r  <= rd_dur;
      otot_r  <= otsr_pkg::TOT_W'(tot_r - otsr_pkg::TOT_W'(rd_dur));
      olast_r <= 1'b1;
    end
    if (cmd.emit_play) begin
      ostat_r <= otsr_pkg::STAT_OK;
      oid_r   <= rd_id;
      okey_r  <= rd_key;
      odur_r  <= rd_dur;
      otot_r  <= tot_r;
      olast_r <= (ptr_inc == cnt_r);
    end
    if (cmd.srt_emit) begin
      ostat_r <= otsr_pkg::STAT_OK;
      oid_r   <= bid_r;
      okey_r  <= bkey_r;
      odur_r  <= bdur_r;
      otot_r  <= tot_r;
      olast_r <= (CNT_W'(ecnt_r + 1'b1) == cnt_r);
    end
  end

  always_comb begin
    sts.req        = req_r;
    sts.full       = (cnt_r == CNT_W'(CAPACITY));
    sts.ids_out    = nid_r[16];
    sts.empty      = (cnt_r == '0);
    sts.hit        = (rd_id == tgt_r);
    sts.scan_end   = (ptr_inc == cnt_r);
    sts.shift_more = (ptr_inc < cnt_r);
    sts.out_busy   = out_valid_r;
    sts.out_last   = olast_r;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = ostat_r;
  assign out_entry_id       = oid_r;
  assign out_entry_key      = otsr_pkg::OKEY_W'(okey_r);
  assign out_entry_duration = odur_r;
  assign out_total_seconds  = otot_r;
  assign out_last           = olast_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> !out_valid_r)
    else $error("result written over a pending transfer");
  a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (tot_r == '0))
    else $error("empty table with nonzero total");
  a_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    nid_r != 17'd0)
    else $error("id counter reached zero");
`endif

endmodule

FILE: hdl/otsr_ctrl.sv
module otsr_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  otsr_pkg::sts_t   sts,
  output otsr_pkg::cmd_t   cmd
);

  otsr_pkg::state_t state_r;
  otsr_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= otsr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = !((state_r == otsr_pkg::ST_IDLE) && !sts.out_busy);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      otsr_pkg::ST_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.load_req = 1'b1;
          state_nxt    = otsr_pkg::ST_DECIDE;
        end
      end
      otsr_pkg::ST_DECIDE: begin
        if (sts.req == otsr_pkg::REQ_ADD) begin
          if (sts.full || sts.ids_out) begin
            cmd.emit_stat = 1'b1;
            cmd.stat      = otsr_pkg::STAT_FULL;
          end else begin
            cmd.do_add = 1'b1;
          end
          state_nxt = otsr_pkg::ST_WAIT;
        end else if (sts.empty) begin
          cmd.emit_stat = 1'b1;
          cmd.stat      = otsr_pkg::STAT_EMPTY;
          state_nxt     = otsr_pkg::ST_WAIT;
        end else begin
          cmd.ptr_clr = 1'b1;
          unique case (sts.req)
            otsr_pkg::REQ_DEL:  state_nxt = otsr_pkg::ST_DEL_RD;
            otsr_pkg::REQ_PLAY: state_nxt = otsr_pkg::ST_PLAY_RD;
            default: begin
              cmd.srt_start  = 1'b1;
              cmd.pass_start = 1'b1;
              state_nxt      = otsr_pkg::ST_SRT_RD;
            end
          endcase
        end
      end
      otsr_pkg::ST_DEL_RD: begin
        state_nxt = otsr_pkg::ST_DEL_EV;
      end
      otsr_pkg::ST_DEL_EV: begin
        if (sts.hit) begin
          cmd.del_hit = 1'b1;
          state_nxt   = otsr_pkg::ST_DEL_SH;
        end else if (sts.scan_end) begin
          cmd.emit_stat = 1'b1;
          cmd.stat      = otsr_pkg::STAT_NOTFOUND;
          state_nxt     = otsr_pkg::ST_WAIT;
        end else begin
          cmd.ptr_inc = 1'b1;
          state_nxt   = otsr_pkg::ST_DEL_RD;
        end
      end
      otsr_pkg::ST_DEL_SH: begin
        if (sts.shift_more) begin
          cmd.rd_next = 1'b1;
          state_nxt   = otsr_pkg::ST_DEL_SW;
        end else begin
          cmd.del_done = 1'b1;
          state_nxt    = otsr_pkg::ST_WAIT;
        end
      end
      otsr_pkg::ST_DEL_SW: begin
        cmd.shift_wr = 1'b1;
        cmd.ptr_inc  = 1'b1;
        state_nxt    = otsr_pkg::ST_DEL_SH;
      end
      otsr_pkg::ST_PLAY_RD: begin
        state_nxt = otsr_pkg::ST_PLAY_EV;
      end
      otsr_pkg::ST_PLAY_EV: begin
        cmd.emit_play = 1'b1;
        cmd.ptr_inc   = 1'b1;
        state_nxt     = otsr_pkg::ST_PLAY_WAIT;
      end
      otsr_pkg::ST_PLAY_WAIT: begin
        if (!sts.out_busy) begin
          state_nxt = sts.out_last ? otsr_pkg::ST_IDLE : otsr_pkg::ST_PLAY_RD;
        end
      end
      otsr_pkg::ST_SRT_RD: begin
        state_nxt = otsr_pkg::ST_SRT_EV;
      end
      otsr_pkg::ST_SRT_EV: begin
        cmd.srt_eval = 1'b1;
        cmd.ptr_inc  = 1'b1;
        state_nxt    = sts.scan_end ? otsr_pkg::ST_SRT_EMIT : otsr_pkg::ST_SRT_RD;
      end
      otsr_pkg::ST_SRT_EMIT: begin
        cmd.srt_emit = 1'b1;
        state_nxt    = otsr_pkg::ST_SRT_WAIT;
      end
      otsr_pkg::ST_SRT_WAIT: begin
        if (!sts.out_busy) begin
          if (sts.out_last) begin
            state_nxt = otsr_pkg::ST_IDLE;
          end else begin
            cmd.ptr_clr    = 1'b1;
            cmd.pass_start = 1'b1;
            state_nxt      = otsr_pkg::ST_SRT_RD;
          end
        end
      end
      otsr_pkg::ST_WAIT: begin
        if (!sts.out_busy) begin
          state_nxt = otsr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = otsr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/ordered_table_with_sorted_readout_unit.sv
// Channel  Handshake          Payload
// in       in_valid/in_stall  req_type, sort_key, duration_seconds, target_id
// out      out_valid/out_stall status, entry_id, entry_key, entry_duration,
//                             total_seconds, last
//
// One request is handled at a time; the input stalls until its last result transfers.
// Add requests and full or empty refusals are answered from the decide step; delete
// searches the entries in order, then shifts each later entry down, on an entry memory
// with one read and one write port. Play in order reads entries in storage order; play
// by key rescans the table for each result.
// Reset empties the table and sets the next id to one; it needs no clearing pass.
// A stalled output only holds the block in its current step.
module ordered_table_with_sorted_readout_unit #(
  parameter int CAPACITY = 64,
  parameter int KEY_BITS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_req_type,
  input  logic [otsr_pkg::OKEY_W-1:0] in_sort_key,
  input  logic [otsr_pkg::DUR_W-1:0]  in_duration_seconds,
  input  logic [otsr_pkg::ID_W-1:0]   in_target_id,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_status,
  output logic [otsr_pkg::ID_W-1:0]   out_entry_id,
  output logic [otsr_pkg::OKEY_W-1:0] out_entry_key,
  output logic [otsr_pkg::DUR_W-1:0]  out_entry_duration,
  output logic [otsr_pkg::TOT_W-1:0]  out_total_seconds,
  output logic                        out_last
);

  otsr_pkg::cmd_t cmd;
  otsr_pkg::sts_t sts;

  otsr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  otsr_dp #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_req_type         (in_req_type),
    .in_sort_key         (in_sort_key),
    .in_duration_seconds (in_duration_seconds),
    .in_target_id        (in_target_id),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_entry_id        (out_entry_id),
    .out_entry_key       (out_entry_key),
    .out_entry_duration  (out_entry_duration),
    .out_total_seconds   (out_total_seconds),
    .out_last            (out_last)
  );

endmodule
